FILE: hw/rtl/bstk_pkg.sv
// Shared types and codes for the bounded stack with statistics.
package bstk_pkg;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         depth;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic signed [39:0] mean_fixed;
    logic [4:0]         match_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/bstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bounded_stack_with_stats.sv
// Bounded stack of signed 32-bit values with max, min, mean and key match statistics.
//
// Each request (push, pop or search) yields one response with status, depth after the
// operation, largest, smallest, mean (signed, 8 fraction bits, truncated toward zero)
// and, for a search, the number of entries equal to the key. Entries live in one RAM;
// after the stack update the block reads back every held entry, one per cycle, then
// divides the scaled sum by the depth with a bit-serial divider of 40 + clog2(STACK_DEPTH+1)
// steps (45 at the default depth); a request that leaves the stack empty skips both phases.
// One request is in work at a time, and the next is taken while a response waits.
module bounded_stack_with_stats #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bstk_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bstk_pkg::rsp_t rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = 32 + CW;
  localparam int DW = SW + 8;
  localparam int BW = $clog2(DW + 1);

  bstk_pkg::state_t state, state_next;

  logic [CW-1:0]        cnt, cnt_acc;
  logic [1:0]           stat_acc, status_r;
  logic [1:0]           kind_r;
  logic signed [31:0]   key_r;
  logic [CW-1:0]        idx;
  logic                 pend, pend_first, pend_last;
  logic signed [31:0]   hi, lo;
  logic signed [SW-1:0] sum;
  logic [CW-1:0]        match_cnt;
  logic                 neg;
  logic [DW-1:0]        quo;
  logic [CW-1:0]        rem;
  logic [BW-1:0]        bitcnt;

  logic                 accept, issue, load_rsp, we;
  logic [AW-1:0]        waddr;
  logic [31:0]          rdata;
  logic signed [31:0]   elem;
  logic [SW-1:0]        sum_mag;
  logic [CW:0]          rem_sh, rem_diff;
  logic                 ge;
  logic [DW-1:0]        mean_full;

  assign accept = req_valid && req_ready;
  assign elem   = rdata;

  // Stack update for the request being taken.
  always_comb begin
    cnt_acc  = cnt;
    stat_acc = bstk_pkg::STAT_OK;
    we       = 1'b0;
    waddr    = cnt[AW-1:0];
    unique case (req.kind)
      bstk_pkg::KIND_PUSH: begin
        if (cnt >= CW'(STACK_DEPTH)) begin
          stat_acc = bstk_pkg::STAT_FULL;
        end else begin
          we      = accept;
          cnt_acc = cnt + CW'(1);
        end
      end
      bstk_pkg::KIND_POP: begin
        if (cnt == '0) begin
          stat_acc = bstk_pkg::STAT_EMPTY;
        end else begin
          cnt_acc = cnt - CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (cnt_acc == '0) begin
      stat_acc = bstk_pkg::STAT_EMPTY;
    end
  end

  bstk_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(req.value),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bstk_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (cnt_acc == '0) ? bstk_pkg::S_DONE : bstk_pkg::S_SCAN;
        end
      end
      bstk_pkg::S_SCAN: if (pend_last) state_next = bstk_pkg::S_PREP;
      bstk_pkg::S_PREP: state_next = bstk_pkg::S_DIV;
      bstk_pkg::S_DIV:  if (bitcnt == BW'(1)) state_next = bstk_pkg::S_DONE;
      bstk_pkg::S_DONE: if (!rsp_valid || rsp_ready) state_next = bstk_pkg::S_IDLE;
      default: state_next = bstk_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_ready = 1'b0;
    issue     = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      bstk_pkg::S_IDLE: req_ready = 1'b1;
      bstk_pkg::S_SCAN: issue = (idx != cnt);
      bstk_pkg::S_DONE: load_rsp = !rsp_valid || rsp_ready;
      default: begin
      end
    endcase
  end

  // Divider step: restoring, one quotient bit per cycle.
  always_comb begin
    sum_mag  = sum[SW-1] ? SW'(-sum) : SW'(sum);
    rem_sh   = {rem, quo[DW-1]};
    ge       = rem_sh >= {1'b0, cnt};
    rem_diff = ge ? (rem_sh - {1'b0, cnt}) : rem_sh;
    mean_full = neg ? DW'(-quo) : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bstk_pkg::S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (accept) begin
        cnt <= cnt_acc;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_first <= issue && (idx == '0);
    pend_last  <= issue && (CW'(idx + CW'(1)) == cnt);
    if (accept) begin
      status_r  <= stat_acc;
      kind_r    <= req.kind;
      key_r     <= req.value;
      idx       <= '0;
      hi        <= '0;
      lo        <= '0;
      sum       <= '0;
      match_cnt <= '0;
      quo       <= '0;
      neg       <= 1'b0;
    end
    if (issue) begin
      idx <= idx + CW'(1);
    end
    // Fold in each entry as its read data returns.
    if (pend) begin
      if (pend_first || elem > hi) hi <= elem;
      if (pend_first || elem < lo) lo <= elem;
      sum <= sum + SW'(elem);
      if (kind_r == bstk_pkg::KIND_SEARCH && elem == key_r) begin
        match_cnt <= match_cnt + CW'(1);
      end
    end
    if (state == bstk_pkg::S_PREP) begin
      neg    <= sum[SW-1];
      quo    <= {sum_mag, 8'b0};
      rem    <= '0;
      bitcnt <= BW'(DW);
    end
    if (state == bstk_pkg::S_DIV) begin
      quo    <= {quo[DW-2:0], ge};
      rem    <= rem_diff[CW-1:0];
      bitcnt <= bitcnt - BW'(1);
    end
    if (load_rsp) begin
      rsp.status      <= status_r;
      rsp.depth       <= 5'(cnt);
      rsp.largest     <= hi;
      rsp.smallest    <= lo;
      rsp.mean_fixed  <= 40'(mean_full);
      rsp.match_count <= 5'(match_cnt);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count above capacity");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == bstk_pkg::S_DIV) |-> (cnt != '0))
    else $error("divide started with empty stack");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> (rsp.smallest <= rsp.largest))
    else $error("smallest above largest in response");
`endif

endmodule
